@@ rtl/vdft_pkg.sv @@
// shared types, constants and helper functions of the vertex dedup fan triangulator
package vdft_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int INDEX_BITS   = 16;
  localparam int FIELD_W      = 16;
  localparam int OUT_VIDX_W   = 10;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = VIDX_W + 1;
  localparam int SLOTS        = 2 * MAX_VERTICES;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int TUPLE_W      = 4 * INDEX_BITS;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRI      = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_TEXCOORDS = 2'd0,
    REG_NORMALS   = 2'd1,
    REG_COLORS    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS-1:0] tex;
    logic [INDEX_BITS-1:0] nrm;
    logic [INDEX_BITS-1:0] col;
  } tuple_t;

  // one queued vertex, already hashed by the front
  typedef struct packed {
    logic              face_start;
    tuple_t            tup;
    logic [SLOT_W-1:0] hash;
  } item_t;

  // one hash table slot
  typedef struct packed {
    logic              valid;
    tuple_t            tup;
    logic [VIDX_W-1:0] vidx;
  } entry_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  last;
    logic [OUT_VIDX_W-1:0] new_vidx;
    logic [FIELD_W-1:0]    pos;
    logic [FIELD_W-1:0]    tex;
    logic [FIELD_W-1:0]    nrm;
    logic [FIELD_W-1:0]    col;
    logic [2:0]            dmask;
    logic [OUT_VIDX_W-1:0] tri_first;
    logic [OUT_VIDX_W-1:0] tri_second;
    logic [OUT_VIDX_W-1:0] tri_third;
  } result_t;

  typedef struct packed {
    logic               clearing;
    logic [COUNT_W-1:0] count;
  } status_t;

  // port field to internal index width
  function automatic logic [INDEX_BITS-1:0] to_tidx(input logic [FIELD_W-1:0] v);
    logic [63:0] w;
    w = {48'b0, v};
    return w[INDEX_BITS-1:0];
  endfunction

  // internal index to port field width
  function automatic logic [FIELD_W-1:0] to_field(input logic [INDEX_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

  // vertex index to output index width
  function automatic logic [OUT_VIDX_W-1:0] to_ovidx(input logic [VIDX_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_VIDX_W-1:0];
  endfunction

  // xor fold of the tuple into a slot address, fields rotated apart
  function automatic logic [SLOT_W-1:0] hash_fn(input tuple_t t);
    logic [SLOT_W-1:0] h;
    logic [TUPLE_W-1:0] v;
    h = '0;
    v = {t.pos, t.tex, t.nrm, t.col};
    for (int b = 0; b < TUPLE_W; b++) begin
      h[(b + 3 * (b / INDEX_BITS)) % SLOT_W] ^= v[b];
    end
    return h;
  endfunction

endpackage

@@ rtl/vdft_front.sv @@
// front part: accepts vertices, hashes the tuple and queues the transaction
module vdft_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    face_start,
  input  logic [15:0]             position_index,
  input  logic [15:0]             texture_index,
  input  logic [15:0]             normal_index,
  input  logic [15:0]             color_index,
  output logic                    q_valid,
  output vdft_pkg::item_t         q_item,
  input  logic                    q_pop
);
  import vdft_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  item_t      incoming;
  logic       push;

  // pack and hash the incoming vertex
  always_comb begin
    incoming.face_start = face_start;
    incoming.tup.pos    = to_tidx(position_index);
    incoming.tup.tex    = to_tidx(texture_index);
    incoming.tup.nrm    = to_tidx(normal_index);
    incoming.tup.col    = to_tidx(color_index);
    incoming.hash       = hash_fn(incoming.tup);
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];

  // two entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= incoming;
        wr_ptr        <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ rtl/vdft_back.sv @@
// back part: hash table probe, dense index assignment, fan triangles and output register
module vdft_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  vdft_pkg::item_t   q_item,
  output logic              q_pop,
  input  logic [2:0]        dmask,
  output logic              out_valid,
  input  logic              out_stall,
  output vdft_pkg::result_t res,
  output vdft_pkg::status_t status
);
  import vdft_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WAIT,
    S_PROBE,
    S_TRI
  } state_t;

  state_t             state;
  logic [SLOT_W-1:0]  clr_addr;
  logic [SLOT_W-1:0]  paddr;
  item_t              item;
  logic [COUNT_W-1:0] count;
  logic [VIDX_W-1:0]  anchor;
  logic [VIDX_W-1:0]  prev;
  logic [1:0]         fpos;
  result_t            tri_pend;

  entry_t             mem [SLOTS];
  entry_t             rd;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  entry_t             wdata;

  logic               out_free;
  logic               hit;
  logic               empty;
  logic               full;
  logic [VIDX_W-1:0]  cur;
  logic               start_face;
  logic               make_tri;
  result_t            vtx_res;
  result_t            tri_res;
  result_t            ovf_res;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign status.clearing = (state == S_CLEAR);
  assign status.count    = count;

  // probe decision
  always_comb begin
    hit        = rd.valid && (rd.tup == item.tup);
    empty      = !rd.valid;
    full       = (count == COUNT_W'(MAX_VERTICES));
    cur        = hit ? rd.vidx : count[VIDX_W-1:0];
    start_face = item.face_start || (fpos == 2'd0);
    make_tri   = !start_face && (fpos == 2'd2);

    vtx_res          = '0;
    vtx_res.kind     = KIND_VERTEX;
    vtx_res.last     = !make_tri;
    vtx_res.new_vidx = to_ovidx(cur);
    vtx_res.pos      = to_field(item.tup.pos);
    vtx_res.tex      = to_field(item.tup.tex);
    vtx_res.nrm      = to_field(item.tup.nrm);
    vtx_res.col      = to_field(item.tup.col);
    vtx_res.dmask    = dmask;

    tri_res            = '0;
    tri_res.kind       = KIND_TRI;
    tri_res.last       = 1'b1;
    tri_res.tri_first  = to_ovidx(anchor);
    tri_res.tri_second = to_ovidx(prev);
    tri_res.tri_third  = to_ovidx(cur);

    ovf_res      = '0;
    ovf_res.kind = KIND_OVERFLOW;
    ovf_res.last = 1'b1;
  end

  // table write port: clearing sweep or insert
  always_comb begin
    we          = 1'b0;
    waddr       = paddr;
    wdata.valid = 1'b1;
    wdata.tup   = item.tup;
    wdata.vidx  = count[VIDX_W-1:0];
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (state == S_PROBE && empty && !full && out_free) begin
      we = 1'b1;
    end
  end

  // hash table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[paddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      anchor    <= '0;
      prev      <= '0;
      fpos      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            paddr <= q_item.hash;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (!hit && !empty) begin
            paddr <= paddr + 1'b1;
            state <= S_WAIT;
          end else if (out_free) begin
            state <= S_IDLE;
            if (empty && full) begin
              res       <= ovf_res;
              out_valid <= 1'b1;
            end else begin
              if (empty) begin
                count <= count + 1'b1;
              end
              if (start_face) begin
                anchor <= cur;
                fpos   <= 2'd1;
              end else begin
                fpos <= 2'd2;
              end
              prev <= cur;
              if (empty) begin
                res       <= vtx_res;
                out_valid <= 1'b1;
                if (make_tri) begin
                  tri_pend <= tri_res;
                  state    <= S_TRI;
                end
              end else if (make_tri) begin
                res       <= tri_res;
                out_valid <= 1'b1;
              end
            end
          end
        end
        S_TRI: begin
          if (out_free) begin
            res       <= tri_pend;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/vertex_dedup_fan_triangulator.sv @@
// top level of the vertex dedup fan triangulator
// Usage:
//   input channel: one face vertex per transaction (face_start, four attribute
//   indices), valid/stall. A two entry queue in the front takes transactions
//   while the back is busy, so in_stall rises only when that queue is full.
//   output channel: result transactions (vertex record, fan triangle or
//   overflow), valid/stall, held in an output register; last marks the final
//   result of one input vertex.
//   config channel: cfg_valid/cfg_ready, always ready; index 0..2 selects
//   texcoords, normals, colors present, bit 0 of cfg_data is written.
// Sequence: the back takes one vertex at a time via S_IDLE, S_WAIT and S_PROBE,
//   with one more S_WAIT and S_PROBE per extra probe, set by the registered read
//   port of the 2*MAX_VERTICES slot table with linear probing, and S_TRI when it
//   gives two results. The first result is registered in S_PROBE once the output
//   register is free; a triangle after a new vertex follows from S_TRI likewise.
// Reset: synchronous rst clears control state, then a pass over all 2048 slots
//   empties the hash table; inputs queue meanwhile but are not processed.
// Stall: a stalled result holds in the output register; the back waits with
//   the next result and the front keeps taking up to two more vertices.
module vertex_dedup_fan_triangulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        face_start,
  input  logic [15:0] position_index,
  input  logic [15:0] texture_index,
  input  logic [15:0] normal_index,
  input  logic [15:0] color_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic        last,
  output logic [9:0]  new_vertex_index,
  output logic [15:0] out_position_index,
  output logic [15:0] out_texture_index,
  output logic [15:0] out_normal_index,
  output logic [15:0] out_color_index,
  output logic [2:0]  defaults_mask,
  output logic [9:0]  tri_first,
  output logic [9:0]  tri_second,
  output logic [9:0]  tri_third,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);
  import vdft_pkg::*;

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;
  status_t status;
  logic    texcoords_present;
  logic    normals_present;
  logic    colors_present;
  logic [2:0] dmask;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      texcoords_present <= 1'b1;
      normals_present   <= 1'b1;
      colors_present    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEXCOORDS: texcoords_present <= cfg_data;
        REG_NORMALS:   normals_present   <= cfg_data;
        REG_COLORS:    colors_present    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dmask = {!colors_present, !normals_present, !texcoords_present};

  vdft_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .face_start     (face_start),
    .position_index (position_index),
    .texture_index  (texture_index),
    .normal_index   (normal_index),
    .color_index    (color_index),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  vdft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .dmask     (dmask),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .status    (status)
  );

  // result fields
  assign result_kind        = res.kind;
  assign last               = res.last;
  assign new_vertex_index   = res.new_vidx;
  assign out_position_index = res.pos;
  assign out_texture_index  = res.tex;
  assign out_normal_index   = res.nrm;
  assign out_color_index    = res.col;
  assign defaults_mask      = res.dmask;
  assign tri_first          = res.tri_first;
  assign tri_second         = res.tri_second;
  assign tri_third          = res.tri_third;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= COUNT_W'(MAX_VERTICES))
    else $error("vertex count above table size");

  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !out_valid)
    else $error("result during clearing pass");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_tri_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_TRI |->
      tri_first == '0 && tri_second == '0 && tri_third == '0)
    else $error("triangle fields set on non-triangle result");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(status.count) |-> status.count == $past(status.count) + 1'b1)
    else $error("vertex count moved by other than one");

endmodule
